/* rtl/time_of_day_clock_with_set_buttons_assert.svh */
// assertion macros for the time of day clock
// used by time_of_day_clock_with_set_buttons.sv, expects clk and rst_n in scope
`ifndef TIME_OF_DAY_CLOCK_WITH_SET_BUTTONS_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_WITH_SET_BUTTONS_ASSERT_SVH

// same-cycle implication
`define TDCLK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdclk assertion failed");

// next-cycle implication
`define TDCLK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdclk assertion failed");

`endif

/* rtl/tdclk_pkg.sv */
// shared types and constants for the time of day clock
// no dependencies
`default_nettype none

package tdclk_pkg;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int LEVEL_W  = 16;
  localparam int BTN_W    = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_BUTTON = 1'b1;

  localparam int BTN_MIN_UP   = 0;
  localparam int BTN_MIN_DOWN = 1;
  localparam int BTN_HOUR_UP  = 2;
  localparam int BTN_HOUR_DOWN = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NIGHT_START = 3'd0,
    REG_NIGHT_END   = 3'd1,
    REG_DIM_LEVEL   = 3'd2,
    REG_BRIGHT_LEVEL = 3'd3,
    REG_FLASH_LEVEL = 3'd4
  } cfg_reg_t;

  localparam logic [HOUR_W-1:0]  RST_NIGHT_START  = 5'd22;
  localparam logic [HOUR_W-1:0]  RST_NIGHT_END    = 5'd5;
  localparam logic [LEVEL_W-1:0] RST_DIM_LEVEL    = 16'd1000;
  localparam logic [LEVEL_W-1:0] RST_BRIGHT_LEVEL = 16'd5000;
  localparam logic [LEVEL_W-1:0] RST_FLASH_LEVEL  = 16'd1;
  localparam logic [LEVEL_W-1:0] RST_BRIGHTNESS   = 16'd2500;

  typedef struct packed {
    logic [HOUR_W-1:0]  night_start;
    logic [HOUR_W-1:0]  night_end;
    logic [LEVEL_W-1:0] dim_level;
    logic [LEVEL_W-1:0] bright_level;
    logic [LEVEL_W-1:0] flash_level;
  } cfg_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                set_flag;
    logic [LEVEL_W-1:0]  brightness;
  } clk_state_t;

  typedef struct packed {
    clk_state_t state;
    logic       restart;
  } step_t;

endpackage

`default_nettype wire

/* rtl/tdclk_ifs.sv */
// valid/ready channel interfaces for requests, results and register writes
// depends on tdclk_pkg
`default_nettype none

interface tdclk_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [tdclk_pkg::BTN_W-1:0] buttons_pressed;
  modport source (output valid, opcode, buttons_pressed, input ready);
  modport sink (input valid, opcode, buttons_pressed, output ready);
endinterface

interface tdclk_out_if;
  logic                           valid;
  logic                           ready;
  logic [tdclk_pkg::HOUR_W-1:0]   hours_now;
  logic [tdclk_pkg::MINUTE_W-1:0] minutes_now;
  logic [tdclk_pkg::SECOND_W-1:0] seconds_now;
  logic [tdclk_pkg::LEVEL_W-1:0]  brightness;
  logic                           time_known;
  logic                           restart_subsecond;
  modport source (output valid, hours_now, minutes_now, seconds_now, brightness,
                  time_known, restart_subsecond, input ready);
  modport sink (input valid, hours_now, minutes_now, seconds_now, brightness,
                time_known, restart_subsecond, output ready);
endinterface

interface tdclk_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tdclk_pkg::CFG_IDX_W-1:0] index;
  logic [tdclk_pkg::LEVEL_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/tdclk_calc.sv */
// next time, brightness and restart flag for one request
// depends on tdclk_pkg
`default_nettype none

module tdclk_calc (
  input  wire tdclk_pkg::clk_state_t      cur,
  input  wire tdclk_pkg::cfg_t            cfg,
  input  wire                             opcode,
  input  wire [tdclk_pkg::BTN_W-1:0]      buttons,
  output tdclk_pkg::step_t                step
);

  logic [tdclk_pkg::HOUR_W-1:0]   tick_hour;
  logic [tdclk_pkg::MINUTE_W-1:0] tick_minute;
  logic [tdclk_pkg::SECOND_W-1:0] tick_second;
  logic                           min_carry;
  logic                           hour_carry;
  logic                           night;

  always_comb begin
    min_carry  = cur.second >= tdclk_pkg::SECOND_MAX;
    tick_second = min_carry ? '0 : cur.second + 6'd1;
    hour_carry = min_carry && (cur.minute >= tdclk_pkg::MINUTE_MAX);
    if (!min_carry) begin
      tick_minute = cur.minute;
    end else if (hour_carry) begin
      tick_minute = '0;
    end else begin
      tick_minute = cur.minute + 6'd1;
    end
    if (!hour_carry) begin
      tick_hour = cur.hour;
    end else if (cur.hour >= tdclk_pkg::HOUR_MAX) begin
      tick_hour = '0;
    end else begin
      tick_hour = cur.hour + 5'd1;
    end

    if (cfg.night_start < cfg.night_end) begin
      night = (tick_hour >= cfg.night_start) && (tick_hour < cfg.night_end);
    end else if (cfg.night_start > cfg.night_end) begin
      night = (tick_hour >= cfg.night_start) || (tick_hour < cfg.night_end);
    end else begin
      night = 1'b0;
    end
  end

  always_comb begin
    step = '{state: cur, restart: 1'b0};
    if (opcode == tdclk_pkg::OP_TICK) begin
      step.state.hour   = tick_hour;
      step.state.minute = tick_minute;
      step.state.second = tick_second;
      if (!cur.set_flag && tick_second[0]) begin
        step.state.brightness = cfg.flash_level;
      end else if (night) begin
        step.state.brightness = cfg.dim_level;
      end else begin
        step.state.brightness = cfg.bright_level;
      end
    end else begin
      step.state.set_flag = 1'b1;
      if (buttons[tdclk_pkg::BTN_MIN_UP]) begin
        step.state.minute = (cur.minute >= tdclk_pkg::MINUTE_MAX) ? '0 : cur.minute + 6'd1;
        step.state.second = '0;
        step.restart      = 1'b1;
      end else if (buttons[tdclk_pkg::BTN_MIN_DOWN]) begin
        step.state.minute = (cur.minute == '0) ? tdclk_pkg::MINUTE_MAX : cur.minute - 6'd1;
        step.state.second = '0;
        step.restart      = 1'b1;
      end else if (buttons[tdclk_pkg::BTN_HOUR_UP]) begin
        step.state.hour = (cur.hour >= tdclk_pkg::HOUR_MAX) ? '0 : cur.hour + 5'd1;
      end else if (buttons[tdclk_pkg::BTN_HOUR_DOWN]) begin
        step.state.hour = (cur.hour == '0) ? tdclk_pkg::HOUR_MAX : cur.hour - 5'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/time_of_day_clock_with_set_buttons.sv */
// top level of the time of day clock: request register, update logic, result register
// depends on tdclk_pkg, tdclk_ifs, tdclk_calc and the assertion macro header
//
//   channel   dir   carries
//   in_ch     in    opcode, buttons_pressed
//   out_ch    out   hours_now, minutes_now, seconds_now, brightness, time_known,
//                   restart_subsecond
//   cfg_ch    in    index, data (register write, always ready)
//
// one request per cycle sustained while out_ch.ready is high; a request passes through
// the request register and then the result register before it shows as a result.
// the time and brightness state updates as a request moves into the result register.
// rst_n is synchronous; a stalled result holds both stages, and during a stall the
// request register takes a request only while it is empty.
`default_nettype none

module time_of_day_clock_with_set_buttons (
  input wire          clk,
  input wire          rst_n,
  tdclk_in_if.sink    in_ch,
  tdclk_out_if.source out_ch,
  tdclk_cfg_if.sink   cfg_ch
);

`include "time_of_day_clock_with_set_buttons_assert.svh"

  tdclk_pkg::cfg_t                cfg_r;
  tdclk_pkg::clk_state_t          state_r;
  tdclk_pkg::step_t               step_nxt;
  tdclk_pkg::step_t               out_r;
  logic                           in_v_r;
  logic                           in_op_r;
  logic [tdclk_pkg::BTN_W-1:0]    in_btn_r;
  logic                           out_v_r;
  logic                           advance;

  assign advance      = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.night_start  <= tdclk_pkg::RST_NIGHT_START;
      cfg_r.night_end    <= tdclk_pkg::RST_NIGHT_END;
      cfg_r.dim_level    <= tdclk_pkg::RST_DIM_LEVEL;
      cfg_r.bright_level <= tdclk_pkg::RST_BRIGHT_LEVEL;
      cfg_r.flash_level  <= tdclk_pkg::RST_FLASH_LEVEL;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tdclk_pkg::REG_NIGHT_START:
          cfg_r.night_start <= cfg_ch.data[tdclk_pkg::HOUR_W-1:0];
        tdclk_pkg::REG_NIGHT_END:
          cfg_r.night_end <= cfg_ch.data[tdclk_pkg::HOUR_W-1:0];
        tdclk_pkg::REG_DIM_LEVEL:    cfg_r.dim_level    <= cfg_ch.data;
        tdclk_pkg::REG_BRIGHT_LEVEL: cfg_r.bright_level <= cfg_ch.data;
        tdclk_pkg::REG_FLASH_LEVEL:  cfg_r.flash_level  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r  <= in_ch.opcode;
      in_btn_r <= in_ch.buttons_pressed;
    end
  end

  tdclk_calc u_calc (
    .cur     (state_r),
    .cfg     (cfg_r),
    .opcode  (in_op_r),
    .buttons (in_btn_r),
    .step    (step_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.hour       <= '0;
      state_r.minute     <= '0;
      state_r.second     <= '0;
      state_r.set_flag   <= 1'b0;
      state_r.brightness <= tdclk_pkg::RST_BRIGHTNESS;
      out_v_r            <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
      if (in_v_r) begin
        state_r <= step_nxt.state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      out_r <= step_nxt;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.hours_now         = out_r.state.hour;
  assign out_ch.minutes_now       = out_r.state.minute;
  assign out_ch.seconds_now       = out_r.state.second;
  assign out_ch.brightness        = out_r.state.brightness;
  assign out_ch.time_known        = out_r.state.set_flag;
  assign out_ch.restart_subsecond = out_r.restart;

  `TDCLK_ASSERT_NEXT(a_stall_holds_state, out_v_r && !out_ch.ready, $stable(state_r))
  `TDCLK_ASSERT_NOW(a_time_in_range, 1'b1,
    (state_r.hour <= tdclk_pkg::HOUR_MAX) && (state_r.minute <= tdclk_pkg::MINUTE_MAX) &&
    (state_r.second <= tdclk_pkg::SECOND_MAX))
  `TDCLK_ASSERT_NOW(a_restart_clears_sec, out_v_r && out_r.restart,
    out_r.state.second == '0 && out_r.state.set_flag)
  `TDCLK_ASSERT_NEXT(a_set_flag_sticky, state_r.set_flag, state_r.set_flag)
  `TDCLK_ASSERT_NEXT(a_result_matches_state, advance && in_v_r,
    out_v_r && out_r.state == state_r)

endmodule

`default_nettype wire
